### design/mtd_pkg.sv
`timescale 1ns / 1ps

package mtd_pkg;

  // Field widths
  localparam int LEVEL_W   = 16;
  localparam int TIME_W    = 32;
  localparam int COUNT_W   = 4;
  localparam int CFG_DW    = 32;
  localparam int CFG_AW    = 2;
  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 8;

  // Register reset values
  localparam logic [LEVEL_W-1:0] LOW_THRESHOLD_RST  = 16'd200;
  localparam logic [LEVEL_W-1:0] HIGH_THRESHOLD_RST = 16'd600;
  localparam logic [TIME_W-1:0]  TAP_TIMEOUT_RST    = 32'd2000;
  localparam logic [COUNT_W-1:0] TAPS_NEEDED_RST    = 4'd4;

  // Register indexes on the configuration port
  typedef enum logic [CFG_AW-1:0] {
    CFG_LOW_THRESHOLD  = 2'd0,
    CFG_HIGH_THRESHOLD = 2'd1,
    CFG_TAP_TIMEOUT    = 2'd2,
    CFG_TAPS_NEEDED    = 2'd3
  } cfg_idx_t;

  // Current register contents, handed to the detector core
  typedef struct packed {
    logic [LEVEL_W-1:0] low_threshold;
    logic [LEVEL_W-1:0] high_threshold;
    logic [TIME_W-1:0]  tap_timeout;
    logic [COUNT_W-1:0] taps_needed;
  } cfg_t;

  // One result item
  typedef struct packed {
    logic [COUNT_W-1:0] edge_count;
    logic               level_active;
    logic               tap_toggle;
  } result_t;

endpackage

### design/multiple_tap_detector.sv
`timescale 1ns / 1ps

// Multiple tap detector.
// Input stream (s_*): one transaction per sample, carrying a signed 16-bit
// level and a 32-bit free-running time stamp. Output stream (m_*): one
// transaction per sample with the toggle flag, the qualified level and the
// current edge count.
// Configuration: cfg_we writes cfg_wdata into register cfg_addr in the same
// cycle (0 low threshold, 1 high threshold, 2 timeout, 3 taps needed).
// Write it only while no transactions are in flight.
// Path: an accepted sample goes through the input register, then the result
// register, before it is presented on m_tvalid.
// Throughput: one transaction per cycle while m_tready is high; the whole update
// is one pass of compare/subtract logic between the input and result registers.
// Stalls: when m_tready is low, the result register holds its transaction and
// the input register can still take one more sample; s_tready drops only
// when both stages are full.
// Reset (rst, synchronous): both stages empty, registers at their defaults,
// hysteresis inactive, count, start time and toggle flag cleared.

module multiple_tap_detector (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [mtd_pkg::CFG_AW-1:0]    cfg_addr,
  input  logic [mtd_pkg::CFG_DW-1:0]    cfg_wdata,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [mtd_pkg::S_TDATA_W-1:0] s_tdata,   // level[15:0], time_now[47:16]
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [mtd_pkg::M_TDATA_W-1:0] m_tdata    // tap_toggle[0], level_active[1],
                                                   // edge_count[5:2], zero[7:6]
);

  mtd_pkg::cfg_t               cfg;
  mtd_pkg::result_t            res;
  mtd_pkg::result_t            out_res;
  logic                        in_valid;
  logic [mtd_pkg::LEVEL_W-1:0] in_level;
  logic [mtd_pkg::TIME_W-1:0]  in_time;
  logic                        advance;
  logic                        s_accept;

  mtd_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .cfg      (cfg)
  );

  mtd_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .level   (in_level),
    .time_now(in_time),
    .cfg     (cfg),
    .res     (res)
  );

  // Handshake: input stage moves on when the result register is free or being taken
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;
  assign s_accept = s_tvalid && s_tready;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_accept) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      in_level <= s_tdata[mtd_pkg::LEVEL_W-1:0];
      in_time  <= s_tdata[mtd_pkg::LEVEL_W +: mtd_pkg::TIME_W];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_tdata = {2'b00, out_res.edge_count, out_res.level_active, out_res.tap_toggle};

  // Reset empties both stages
  a_reset_empty: assert property (@(posedge clk) rst |=> !in_valid && !m_tvalid)
    else $error("pipeline not empty after reset");

  // An empty input stage never refuses a sample
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> s_tready)
    else $error("s_tready low with empty input stage");

  // A transaction moved forward is presented next cycle
  a_advance_presents: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_tvalid)
    else $error("advanced transaction not presented");

  // A taken result with nothing behind it leaves the output empty
  a_drain: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !advance |=> !m_tvalid)
    else $error("result repeated after being taken");

  // Input stage fills only through an accepted sample
  a_fill_source: assert property (@(posedge clk) disable iff (rst)
    !in_valid && !s_accept |=> !in_valid)
    else $error("input stage filled without a transaction");

endmodule

### design/mtd_cfg_regs.sv
`timescale 1ns / 1ps

module mtd_cfg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [mtd_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [mtd_pkg::CFG_DW-1:0]  cfg_wdata,
  output mtd_pkg::cfg_t               cfg
);

  // Register file, write only
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.low_threshold  <= mtd_pkg::LOW_THRESHOLD_RST;
      cfg.high_threshold <= mtd_pkg::HIGH_THRESHOLD_RST;
      cfg.tap_timeout    <= mtd_pkg::TAP_TIMEOUT_RST;
      cfg.taps_needed    <= mtd_pkg::TAPS_NEEDED_RST;
    end else if (cfg_we) begin
      unique case (mtd_pkg::cfg_idx_t'(cfg_addr))
        mtd_pkg::CFG_LOW_THRESHOLD: begin
          cfg.low_threshold <= cfg_wdata[mtd_pkg::LEVEL_W-1:0];
        end
        mtd_pkg::CFG_HIGH_THRESHOLD: begin
          cfg.high_threshold <= cfg_wdata[mtd_pkg::LEVEL_W-1:0];
        end
        mtd_pkg::CFG_TAP_TIMEOUT: begin
          cfg.tap_timeout <= cfg_wdata[mtd_pkg::TIME_W-1:0];
        end
        mtd_pkg::CFG_TAPS_NEEDED: begin
          cfg.taps_needed <= cfg_wdata[mtd_pkg::COUNT_W-1:0];
        end
        default: ;
      endcase
    end
  end

endmodule

### design/mtd_core.sv
`timescale 1ns / 1ps

module mtd_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        advance,
  input  logic [mtd_pkg::LEVEL_W-1:0] level,
  input  logic [mtd_pkg::TIME_W-1:0]  time_now,
  input  mtd_pkg::cfg_t               cfg,
  output mtd_pkg::result_t            res
);

  logic                        hyst_state;
  logic [mtd_pkg::COUNT_W-1:0] pulse_count;
  logic [mtd_pkg::TIME_W-1:0]  start_time;
  logic                        toggle_flag;

  logic                        act;
  logic                        pulse;
  logic                        count_zero;
  logic [mtd_pkg::TIME_W-1:0]  start_time_next;
  logic [mtd_pkg::TIME_W-1:0]  elapsed;
  logic                        timeout;
  logic [mtd_pkg::COUNT_W-1:0] base;
  logic [mtd_pkg::COUNT_W-1:0] kept;
  logic [mtd_pkg::COUNT_W-1:0] pulse_count_next;
  logic                        toggle_flag_next;

  // Hysteresis: threshold depends on the current qualified level
  always_comb begin
    if (hyst_state) begin
      act = $signed(level) > $signed(cfg.low_threshold);
    end else begin
      act = $signed(level) > $signed(cfg.high_threshold);
    end
  end

  assign pulse      = act ^ hyst_state;
  assign count_zero = (pulse_count == '0);

  // Start time latches on the first rising edge of a run
  assign start_time_next = (act && pulse && count_zero) ? time_now : start_time;
  assign elapsed         = time_now - start_time_next;
  assign timeout         = elapsed > cfg.tap_timeout;

  // Count update: a falling edge with no run in progress is not counted
  assign base = (!act && count_zero) ? '0 : {{(mtd_pkg::COUNT_W-1){1'b0}}, pulse};
  assign kept = ((pulse_count >= cfg.taps_needed) || timeout) ? '0 : pulse_count;
  assign pulse_count_next = base + kept;

  assign toggle_flag_next = toggle_flag ^
                            ((pulse_count_next >= cfg.taps_needed) && !timeout);

  // State advances once per transaction moved to the output stage
  always_ff @(posedge clk) begin
    if (rst) begin
      hyst_state  <= 1'b0;
      pulse_count <= '0;
      start_time  <= '0;
      toggle_flag <= 1'b0;
    end else if (advance) begin
      hyst_state  <= act;
      pulse_count <= pulse_count_next;
      start_time  <= start_time_next;
      toggle_flag <= toggle_flag_next;
    end
  end

  assign res.tap_toggle   = toggle_flag_next;
  assign res.level_active = act;
  assign res.edge_count   = pulse_count_next;

endmodule

### dv/mtd_checker.sv
`timescale 1ns / 1ps

// Scoreboard for the multiple tap detector: mirrors the register file,
// predicts one result per accepted sample and compares the output stream
// in order against the predictions.
module mtd_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [mtd_pkg::CFG_AW-1:0]    cfg_addr,
  input  logic [mtd_pkg::CFG_DW-1:0]    cfg_wdata,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [mtd_pkg::S_TDATA_W-1:0] s_tdata,   // level[15:0], time_now[47:16]
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [mtd_pkg::M_TDATA_W-1:0] m_tdata,   // tap_toggle[0], level_active[1],
                                                   // edge_count[5:2], zero[7:6]
  output int                            errors,
  output int                            pending,
  output int                            checked,
  output int                            toggles,
  output int                            expiries
);

  // Register mirror
  logic signed [15:0] low_thr;
  logic signed [15:0] high_thr;
  logic [31:0]        window;
  logic [3:0]         needed;

  // Detector state mirror
  logic               hyst;
  logic [3:0]         count;
  logic [31:0]        t_start;
  logic               flag;

  mtd_pkg::result_t   result_q[$];
  mtd_pkg::result_t   want;
  mtd_pkg::result_t   got;
  int                 fail_n;
  int                 check_n;
  int                 toggle_n;
  int                 expiry_n;

  // One detector step: hysteresis, edge counting, window check, toggle
  function automatic mtd_pkg::result_t tap_step(input logic [15:0] lvl_raw,
                                                input logic [31:0] now);
    logic signed [15:0] lvl;
    logic               act;
    logic               pulse;
    logic               late;
    logic [31:0]        t0;
    logic [3:0]         cnt;
    logic [3:0]         kept;
    mtd_pkg::result_t   r;
    lvl   = lvl_raw;
    act   = hyst ? (lvl > low_thr) : (lvl > high_thr);
    pulse = (act != hyst);
    // start of window latched on the first rising edge of a burst
    t0    = (act && pulse && count == 4'd0) ? now : t_start;
    late  = (now - t0) > window;
    cnt   = (!act && count == 4'd0) ? 4'd0 : {3'd0, pulse};
    kept  = (count >= needed || late) ? 4'd0 : count;
    if (late && count != 4'd0) expiry_n++;
    cnt = cnt + kept;
    if (cnt >= needed && !late) begin
      flag = ~flag;
      toggle_n++;
    end
    count   = cnt;
    hyst    = act;
    t_start = t0;
    r.tap_toggle   = flag;
    r.level_active = hyst;
    r.edge_count   = count;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      low_thr  = mtd_pkg::LOW_THRESHOLD_RST;
      high_thr = mtd_pkg::HIGH_THRESHOLD_RST;
      window   = mtd_pkg::TAP_TIMEOUT_RST;
      needed   = mtd_pkg::TAPS_NEEDED_RST;
      hyst     = 1'b0;
      count    = 4'd0;
      t_start  = 32'd0;
      flag     = 1'b0;
      fail_n   = 0;
      check_n  = 0;
      toggle_n = 0;
      expiry_n = 0;
      result_q.delete();
    end else begin
      // register writes
      if (cfg_we) begin
        case (mtd_pkg::cfg_idx_t'(cfg_addr))
          mtd_pkg::CFG_LOW_THRESHOLD:  low_thr  = cfg_wdata[15:0];
          mtd_pkg::CFG_HIGH_THRESHOLD: high_thr = cfg_wdata[15:0];
          mtd_pkg::CFG_TAP_TIMEOUT:    window   = cfg_wdata[31:0];
          mtd_pkg::CFG_TAPS_NEEDED:    needed   = cfg_wdata[3:0];
          default: ;
        endcase
      end

      // input transaction: predict its result
      if (s_tvalid && s_tready)
        result_q.push_back(tap_step(s_tdata[15:0], s_tdata[47:16]));

      // output transaction: compare with oldest prediction
      if (m_tvalid && m_tready) begin
        got = m_tdata[5:0];
        if (result_q.size() == 0) begin
          fail_n++;
          if (fail_n <= 10)
            $display("%0t: unexpected result toggle=%0b active=%0b count=%0d",
                     $time, got.tap_toggle, got.level_active, got.edge_count);
        end else begin
          want = result_q.pop_front();
          check_n++;
          if (got.tap_toggle !== want.tap_toggle ||
              got.level_active !== want.level_active ||
              got.edge_count !== want.edge_count ||
              m_tdata[7:6] !== 2'b00) begin
            fail_n++;
            if (fail_n <= 10)
              $display({"%0t: result mismatch: want toggle=%0b active=%0b count=%0d,",
                        " got toggle=%0b active=%0b count=%0d pad=%b"},
                       $time, want.tap_toggle, want.level_active, want.edge_count,
                       got.tap_toggle, got.level_active, got.edge_count, m_tdata[7:6]);
          end
        end
      end
    end

    errors   <= fail_n;
    pending  <= result_q.size();
    checked  <= check_n;
    toggles  <= toggle_n;
    expiries <= expiry_n;
  end

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int PHASES        = 8;
  localparam int RANDOM_ITEMS  = 118;

  logic                          clk;
  logic                          rst;
  logic                          cfg_we;
  logic [mtd_pkg::CFG_AW-1:0]    cfg_addr;
  logic [mtd_pkg::CFG_DW-1:0]    cfg_wdata;
  logic                          s_tvalid;
  logic                          s_tready;
  logic [mtd_pkg::S_TDATA_W-1:0] s_tdata;
  logic                          m_tvalid;
  logic                          m_tready;
  logic [mtd_pkg::M_TDATA_W-1:0] m_tdata;

  int                    errors;
  int                    pending;
  int                    checked;
  int                    toggles;
  int                    expiries;

  // Stimulus-side view of the current setting, used to aim levels and times
  logic signed [15:0]    cur_low;
  logic signed [15:0]    cur_high;
  logic [31:0]           cur_window;
  logic [3:0]            cur_needed;
  logic [31:0]           tstamp;
  int                    tx_idle_pct;
  int                    rx_stall_pct;
  int                    samples_sent;

  multiple_tap_detector uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  mtd_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .errors    (errors),
    .pending   (pending),
    .checked   (checked),
    .toggles   (toggles),
    .expiries  (expiries)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run limit
  initial begin
    #4_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Receiver back-pressure
  always @(posedge clk)
    m_tready <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);

  // One input transaction, with optional idle cycles ahead of it
  task automatic send_sample(input logic [15:0] lvl, input logic [31:0] ts);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {ts, lvl};
    do @(posedge clk); while (!s_tready);
    samples_sent++;
  endtask

  // Stop sending and wait for every outstanding result
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input mtd_pkg::cfg_idx_t idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // Register settings per phase; junk in the upper bits of the threshold and taps-needed writes
  task automatic load_setting(input int ph);
    case (ph)
      1: begin
        cur_low = 16'sd200;  cur_high = 16'sd600;  cur_window = 32'd2000;
        cur_needed = 4'd1;
      end
      2: begin
        cur_low = -16'sd32768; cur_high = 16'sd32767; cur_window = 32'hFFFF_FFFF;
        cur_needed = 4'd15;
      end
      3: begin
        cur_low = -16'sd32768; cur_high = -16'sd32768; cur_window = 32'd0;
        cur_needed = 4'd2;
      end
      4: begin  // thresholds crossed over, zero taps needed
        cur_low = 16'sd1000; cur_high = -16'sd1000; cur_window = 32'd500;
        cur_needed = 4'd0;
      end
      5: begin
        cur_low = -16'sd500; cur_high = 16'sd500; cur_window = 32'd100000;
        cur_needed = 4'd15;
      end
      6: begin
        cur_low = 16'($urandom); cur_high = 16'($urandom); cur_window = $urandom;
        cur_needed = 4'($urandom_range(15));
      end
      default: begin
        cur_low = 16'($urandom); cur_high = 16'($urandom);
        cur_window = $urandom_range(5000, 50); cur_needed = 4'd3;
      end
    endcase
    write_reg(mtd_pkg::CFG_LOW_THRESHOLD,  {16'($urandom), cur_low});
    write_reg(mtd_pkg::CFG_HIGH_THRESHOLD, {16'($urandom), cur_high});
    write_reg(mtd_pkg::CFG_TAP_TIMEOUT,    cur_window);
    write_reg(mtd_pkg::CFG_TAPS_NEEDED,    {28'($urandom), cur_needed});
    cfg_we <= 1'b0;
  endtask

  // Level aimed above or below both thresholds, with some edge and noise values
  function automatic logic [15:0] pick_level(input bit up);
    int hi_t;
    int lo_t;
    int r;
    hi_t = (cur_low > cur_high) ? cur_low : cur_high;
    lo_t = (cur_low > cur_high) ? cur_high : cur_low;
    r = $urandom_range(99);
    if (r < 5)       return 16'(cur_low + $urandom_range(2) - 1);
    else if (r < 10) return 16'(cur_high + $urandom_range(2) - 1);
    else if (r < 20) return 16'($urandom);
    else if (up)     return (hi_t >= 32767) ? 16'h7FFF
                            : 16'(hi_t + 1 + int'($urandom_range(32766 - hi_t)));
    else             return 16'(-32768 + int'($urandom_range(lo_t + 32768)));
  endfunction

  // Mostly short steps inside the window, some expiries and random jumps
  task automatic advance_time();
    int          r;
    logic [31:0] span;
    r = $urandom_range(99);
    span = (cur_window > 32'd2000) ? 32'd400 : cur_window / 4;
    if (r < 15)      tstamp = tstamp + $urandom_range(1);
    else if (r < 75) tstamp = tstamp + $urandom_range(span);
    else if (r < 88) tstamp = tstamp + $urandom_range(
                                (cur_window > 32'd3000) ? 3000 : cur_window);
    else if (r < 97) tstamp = tstamp + cur_window + 1 + $urandom_range(100);
    else             tstamp = $urandom;
  endtask

  initial begin
    bit up;
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_addr     = '0;
    cfg_wdata    = '0;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    m_tready     = 1'b1;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    samples_sent = 0;
    up           = 1'b0;
    cur_low      = mtd_pkg::LOW_THRESHOLD_RST;
    cur_high     = mtd_pkg::HIGH_THRESHOLD_RST;
    cur_window   = mtd_pkg::TAP_TIMEOUT_RST;
    cur_needed   = mtd_pkg::TAPS_NEEDED_RST;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset setting, threshold edges, a full burst, expiry, wrap
    send_sample(16'h8000, 32'd0);
    send_sample(16'd600,  32'd5);           // equal to high threshold: stays low
    send_sample(16'd601,  32'd10);          // rises, window opens
    send_sample(16'd201,  32'd20);          // held by low threshold
    send_sample(16'd200,  32'd30);          // equal to low threshold: falls
    send_sample(16'h7FFF, 32'd40);
    send_sample(16'd0,    32'd50);          // fourth edge: flag toggles
    send_sample(16'h7FFF, 32'd60);          // full count restarts
    send_sample(16'hFFFF, 32'd70);
    send_sample(16'h7FFF, 32'd5000);        // window expired
    send_sample(16'h8000, 32'd5010);
    send_sample(16'h8000, 32'd5020);        // quiet step clears the count
    send_sample(16'h7FFF, 32'hFFFF_FFFF);   // window opens just before wrap
    send_sample(16'd0,    32'h0000_0010);
    send_sample(16'h7FFF, 32'h0000_0020);
    send_sample(16'd0,    32'h0000_0030);   // burst across the wrap toggles
    send_sample(16'd0,    32'd100000);
    send_sample(16'h7FFF, 32'd100010);
    send_sample(16'd0,    32'd102010);      // elapsed equals timeout: still inside
    send_sample(16'h7FFF, 32'd102011);      // one past the timeout
    send_sample(16'h5555, 32'hAAAA_AAAA);
    send_sample(16'hAAAA, 32'h5555_5555);
    tstamp = 32'h5555_5555;

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph != 0) begin
        drain();
        load_setting(ph);
        if (ph % 3 == 0) tstamp = $urandom;
      end
      case (ph % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct <= 0;  end
        1: begin tx_idle_pct = 67; rx_stall_pct <= 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct <= 67; end
        default: begin tx_idle_pct = 19; rx_stall_pct <= 19; end
      endcase
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
        if ($urandom_range(99) < 85) up = ~up;
        advance_time();
        send_sample(pick_level(up), tstamp);
      end
    end

    drain();
    rx_stall_pct <= 0;
    repeat (8) @(posedge clk);

    $display("Sent %0d samples over %0d register settings; %0d results checked.",
             samples_sent, PHASES, checked);
    $display("Output flag toggled %0d times, tap window expired %0d times.",
             toggles, expiries);
    if (pending != 0) $display("%0d predicted results never arrived", pending);
    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
